// ===== design/usbpd_cs_pkg.sv =====
// Shared types, constants and lookup functions of the USB PD sink contract selector.
// Used by usbpd_cs_request and usb_pd_sink_contract_select; depends on nothing else.
`default_nettype none

package usbpd_cs_pkg;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_FIXED = 2'd1,
		KIND_PROG  = 2'd2
	} kind_t;

	localparam int NUM_FIXED = 5;
	localparam int NUM_PROG  = 3;

	// Fixed level select field: level number 1..5, 0 = none seen yet
	localparam logic [2:0] LVL_NONE = 3'd0;

	localparam int VMAX_0_MV = 5900;
	localparam int VMAX_1_MV = 11000;
	localparam int VMAX_2_MV = 16000;
	localparam int VMAX_3_MV = 21000;
	localparam int VMIN_0_MV = 3000;
	localparam int VMIN_1_MV = 3300;
	localparam int VMIN_2_MV = 5000;

	localparam int FIXED_0_MV = 5000;
	localparam int FIXED_1_MV = 9000;
	localparam int FIXED_2_MV = 12000;
	localparam int FIXED_3_MV = 15000;
	localparam int FIXED_4_MV = 20000;

	localparam int VOLT_BASE_MV = 3000;
	localparam int VOLT_STEP_MV = 20;
	localparam int POWER_DIV    = 10000;
	localparam int CURRENT_STEP_MA = 100;

	localparam logic [7:0] SHADOW_KEEP_MASK = 8'hFC;
	localparam logic [7:0] FINAL_KEEP_MASK  = 8'h07;
	localparam logic [7:0] GO_KEEP_MASK     = 8'hE0;
	localparam logic [7:0] GO_CMD           = 8'h01;
	localparam logic [3:0] PROG_SEL_BASE    = 4'd6;

	// Power = code * mv / 10000 = (code * mul) >> PWR_SHIFT, exact for 7-bit codes
	localparam int PWR_SHIFT = 20;
	localparam int PWR_MUL_W = 22;
	localparam int PWR_HUND  = POWER_DIV / 100;

	localparam logic [PWR_MUL_W-1:0] PWR_MUL_F0 =
		PWR_MUL_W'((((FIXED_0_MV / 100) << PWR_SHIFT) + PWR_HUND - 1) / PWR_HUND);
	localparam logic [PWR_MUL_W-1:0] PWR_MUL_F1 =
		PWR_MUL_W'((((FIXED_1_MV / 100) << PWR_SHIFT) + PWR_HUND - 1) / PWR_HUND);
	localparam logic [PWR_MUL_W-1:0] PWR_MUL_F2 =
		PWR_MUL_W'((((FIXED_2_MV / 100) << PWR_SHIFT) + PWR_HUND - 1) / PWR_HUND);
	localparam logic [PWR_MUL_W-1:0] PWR_MUL_F3 =
		PWR_MUL_W'((((FIXED_3_MV / 100) << PWR_SHIFT) + PWR_HUND - 1) / PWR_HUND);
	localparam logic [PWR_MUL_W-1:0] PWR_MUL_F4 =
		PWR_MUL_W'((((FIXED_4_MV / 100) << PWR_SHIFT) + PWR_HUND - 1) / PWR_HUND);
	localparam logic [PWR_MUL_W-1:0] PWR_MUL_P0 =
		PWR_MUL_W'((((VMAX_0_MV / 100) << PWR_SHIFT) + PWR_HUND - 1) / PWR_HUND);
	localparam logic [PWR_MUL_W-1:0] PWR_MUL_P1 =
		PWR_MUL_W'((((VMAX_1_MV / 100) << PWR_SHIFT) + PWR_HUND - 1) / PWR_HUND);
	localparam logic [PWR_MUL_W-1:0] PWR_MUL_P2 =
		PWR_MUL_W'((((VMAX_2_MV / 100) << PWR_SHIFT) + PWR_HUND - 1) / PWR_HUND);
	localparam logic [PWR_MUL_W-1:0] PWR_MUL_P3 =
		PWR_MUL_W'((((VMAX_3_MV / 100) << PWR_SHIFT) + PWR_HUND - 1) / PWR_HUND);

	// (mv - 3000) / 20: drop two bits, then divide by 5 through a 16-bit reciprocal
	localparam int DIV5_SHIFT = 16;
	localparam logic [13:0] DIV5_MUL = 14'(((1 << DIV5_SHIFT) + 4) / 5);

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] vlow;
		logic [7:0] cur;
		logic [7:0] final_byte;
		logic [7:0] go;
	} prog_bytes_t;

	typedef struct packed {
		kind_t       kind;
		prog_bytes_t bytes;
		logic [8:0]  power;
		logic [13:0] current_ma;
	} result_t;

	function automatic logic [14:0] vmax_mv(input logic [1:0] code);
		logic [14:0] mv;
		unique case (code)
			2'd0:    mv = 15'(VMAX_0_MV);
			2'd1:    mv = 15'(VMAX_1_MV);
			2'd2:    mv = 15'(VMAX_2_MV);
			default: mv = 15'(VMAX_3_MV);
		endcase
		return mv;
	endfunction

	function automatic logic [14:0] vmin_mv(input logic [1:0] code);
		logic [14:0] mv;
		case (code)
			2'd0:    mv = 15'(VMIN_0_MV);
			2'd1:    mv = 15'(VMIN_1_MV);
			default: mv = 15'(VMIN_2_MV);
		endcase
		return mv;
	endfunction

	function automatic logic [9:0] vmax_vcode(input logic [1:0] code);
		logic [9:0] vc;
		unique case (code)
			2'd0:    vc = 10'((VMAX_0_MV - VOLT_BASE_MV) / VOLT_STEP_MV);
			2'd1:    vc = 10'((VMAX_1_MV - VOLT_BASE_MV) / VOLT_STEP_MV);
			2'd2:    vc = 10'((VMAX_2_MV - VOLT_BASE_MV) / VOLT_STEP_MV);
			default: vc = 10'((VMAX_3_MV - VOLT_BASE_MV) / VOLT_STEP_MV);
		endcase
		return vc;
	endfunction

	function automatic logic [PWR_MUL_W-1:0] pwr_mul_prog(input logic [1:0] code);
		logic [PWR_MUL_W-1:0] m;
		unique case (code)
			2'd0:    m = PWR_MUL_P0;
			2'd1:    m = PWR_MUL_P1;
			2'd2:    m = PWR_MUL_P2;
			default: m = PWR_MUL_P3;
		endcase
		return m;
	endfunction

	// idx is the fixed level position 0..4
	function automatic logic [PWR_MUL_W-1:0] pwr_mul_fixed(input logic [2:0] idx);
		logic [PWR_MUL_W-1:0] m;
		unique case (idx)
			3'd0:    m = PWR_MUL_F0;
			3'd1:    m = PWR_MUL_F1;
			3'd2:    m = PWR_MUL_F2;
			3'd3:    m = PWR_MUL_F3;
			3'd4:    m = PWR_MUL_F4;
			default: m = '0;
		endcase
		return m;
	endfunction

	// lvl is the level number 1..5; no level reads as 0 mV
	function automatic logic [14:0] fixed_mv(input logic [2:0] lvl);
		logic [14:0] mv;
		unique case (lvl)
			3'd1:    mv = 15'(FIXED_0_MV);
			3'd2:    mv = 15'(FIXED_1_MV);
			3'd3:    mv = 15'(FIXED_2_MV);
			3'd4:    mv = 15'(FIXED_3_MV);
			3'd5:    mv = 15'(FIXED_4_MV);
			default: mv = '0;
		endcase
		return mv;
	endfunction

endpackage

`default_nettype wire

// ===== design/usbpd_cs_request.sv =====
// Builds the register bytes of a programmable-supply request.
// Depends on usbpd_cs_pkg.
`default_nettype none

module usbpd_cs_request (
	input  wire logic [1:0]                idx,
	input  wire logic [9:0]                vcode,
	input  wire logic [7:0]                shadow,
	input  wire logic [6:0]                current,
	output      usbpd_cs_pkg::prog_bytes_t bytes
);
	import usbpd_cs_pkg::*;

	logic [7:0] first;
	logic [7:0] final_byte;
	logic [4:0] sel_field;

	// merge voltage high bits into the shadow, then put the supply select in bits 7:3
	assign first      = (shadow & SHADOW_KEEP_MASK) | {6'b0, vcode[9:8]};
	assign sel_field  = 5'(PROG_SEL_BASE + {2'b00, idx});
	assign final_byte = {sel_field, 3'b000} | (first & FINAL_KEEP_MASK);

	assign bytes.first      = first;
	assign bytes.vlow       = vcode[7:0];
	assign bytes.cur        = {current, 1'b0};
	assign bytes.final_byte = final_byte;
	assign bytes.go         = (final_byte & GO_KEEP_MASK) | GO_CMD;

endmodule

`default_nettype wire

// ===== design/usb_pd_sink_contract_select.sv =====
// USB PD sink contract selector: top level with input register, select logic and result register.
// Depends on usbpd_cs_pkg and usbpd_cs_request.
//
// One request enters per cycle while in_stall is low. Acceptance loads the input register and
// the request then moves on into the result register, which drives the outputs. When out_stall
// stays low the sustained rate is one request per cycle, set by the single pass of decode,
// a few small constant and table multipliers and compares between the
// two registers. Command 0 latches the programmable-supply snapshot and
// the request register readback and picks the better of the highest fixed level and the
// highest programmable supply; command 1 checks requested_mv against the stored supplies in
// order and requests it from the first that fits. A full input register with a stalled
// result holds in_stall high. Reset clears all stored capability and shadow state.
`default_nettype none

module usb_pd_sink_contract_select (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic        command,
	input  wire logic [6:0]  fixed_current_0,
	input  wire logic [6:0]  fixed_current_1,
	input  wire logic [6:0]  fixed_current_2,
	input  wire logic [6:0]  fixed_current_3,
	input  wire logic [6:0]  fixed_current_4,
	input  wire logic [6:0]  prog_current_0,
	input  wire logic [6:0]  prog_current_1,
	input  wire logic [6:0]  prog_current_2,
	input  wire logic [7:0]  prog_voltage_codes,
	input  wire logic [7:0]  request_reg_readback,
	input  wire logic [14:0] requested_mv,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [1:0]  request_kind,
	output      logic [7:0]  request_first,
	output      logic [7:0]  voltage_low,
	output      logic [7:0]  current_byte,
	output      logic [7:0]  request_final,
	output      logic [7:0]  go_byte,
	output      logic [8:0]  max_power,
	output      logic [13:0] max_current_ma
);
	import usbpd_cs_pkg::*;

	// input register
	logic        valid_s1;
	logic        cmd_s1;
	logic [6:0]  fc_s1 [NUM_FIXED];
	logic [6:0]  pc_s1 [NUM_PROG];
	logic [7:0]  vcodes_s1;
	logic [7:0]  readback_s1;
	logic [14:0] mv_s1;

	// stored capability and request state
	logic [6:0]  prog_cur_q [NUM_PROG];
	logic [1:0]  prog_max_q [NUM_PROG];
	logic [1:0]  prog_min_q;
	logic [7:0]  shadow_q;
	logic [2:0]  fixed_lvl_q;
	logic [8:0]  fixed_pow_q;

	// result register
	logic        valid_s2;
	result_t     res_s2;

	logic        accept;
	logic        advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= command;
			fc_s1[0]    <= fixed_current_0;
			fc_s1[1]    <= fixed_current_1;
			fc_s1[2]    <= fixed_current_2;
			fc_s1[3]    <= fixed_current_3;
			fc_s1[4]    <= fixed_current_4;
			pc_s1[0]    <= prog_current_0;
			pc_s1[1]    <= prog_current_1;
			pc_s1[2]    <= prog_current_2;
			vcodes_s1   <= prog_voltage_codes;
			readback_s1 <= request_reg_readback;
			mv_s1       <= requested_mv;
		end
	end

	// snapshot decode
	logic [1:0]  pmax_new [NUM_PROG];
	logic [1:0]  psel;
	logic        pany;
	logic [2:0]  fsel;
	logic        fany;
	logic [28:0] pprod;
	logic [28:0] fprod;
	logic [8:0]  ppow;
	logic [2:0]  lvl_new;
	logic [8:0]  fpow_new;
	logic        take_prog;

	assign pmax_new[0] = vcodes_s1[7:6];
	assign pmax_new[1] = vcodes_s1[5:4];
	assign pmax_new[2] = vcodes_s1[3:2];

	// highest present level wins
	always_comb begin
		psel = '0;
		pany = 1'b0;
		for (int i = 0; i < NUM_PROG; i++) begin
			if (pc_s1[i] != '0) begin
				psel = 2'(i);
				pany = 1'b1;
			end
		end
		fsel = '0;
		fany = 1'b0;
		for (int i = 0; i < NUM_FIXED; i++) begin
			if (fc_s1[i] != '0) begin
				fsel = 3'(i);
				fany = 1'b1;
			end
		end
	end

	assign pprod = 29'(pc_s1[psel]) * 29'(pwr_mul_prog(pmax_new[psel]));
	assign fprod = 29'(fc_s1[fsel]) * 29'(pwr_mul_fixed(fsel));
	assign ppow  = pprod[PWR_SHIFT +: 9];

	// an absent fixed set keeps the last level
	assign lvl_new  = fany ? 3'(fsel + 3'd1) : fixed_lvl_q;
	assign fpow_new = fany ? fprod[PWR_SHIFT +: 9] : fixed_pow_q;

	assign take_prog = pany && (vmax_mv(pmax_new[psel]) > fixed_mv(lvl_new))
		&& (ppow > fpow_new);

	// user request fit check against stored supplies
	logic [NUM_PROG-1:0] fit;
	logic [1:0]  fidx;
	logic        fit_any;
	logic [14:0] mv_off;
	logic [29:0] uprod;
	logic [9:0]  ucode;

	always_comb begin
		for (int i = 0; i < NUM_PROG; i++) begin
			fit[i] = (prog_cur_q[i] != '0) && (vmin_mv(prog_min_q) <= mv_s1)
				&& (mv_s1 < vmax_mv(prog_max_q[i]));
		end
		fidx = '0;
		for (int i = NUM_PROG - 1; i >= 0; i--) begin
			if (fit[i]) begin
				fidx = 2'(i);
			end
		end
	end

	assign fit_any = |fit;
	assign mv_off  = mv_s1 - 15'(VOLT_BASE_MV);
	assign uprod   = 30'(mv_off[14:2]) * 30'(DIV5_MUL);
	assign ucode   = uprod[DIV5_SHIFT +: 10];

	// shared request byte builder
	logic [1:0]  rq_idx;
	logic [9:0]  rq_vcode;
	logic [7:0]  rq_shadow;
	logic [6:0]  rq_current;
	prog_bytes_t rq_bytes;

	assign rq_idx     = cmd_s1 ? fidx : psel;
	assign rq_vcode   = cmd_s1 ? ucode : vmax_vcode(pmax_new[psel]);
	assign rq_shadow  = cmd_s1 ? shadow_q : readback_s1;
	assign rq_current = cmd_s1 ? prog_cur_q[fidx] : pc_s1[psel];

	usbpd_cs_request u_request (
		.idx     (rq_idx),
		.vcode   (rq_vcode),
		.shadow  (rq_shadow),
		.current (rq_current),
		.bytes   (rq_bytes)
	);

	result_t res_nxt;

	always_comb begin
		res_nxt = '0;
		if (!cmd_s1) begin
			if (take_prog) begin
				res_nxt.kind  = KIND_PROG;
				res_nxt.bytes = rq_bytes;
				res_nxt.power = ppow;
			end else begin
				if (lvl_new != LVL_NONE) begin
					res_nxt.kind             = KIND_FIXED;
					res_nxt.bytes.first      = {2'b00, lvl_new, 3'b000};
					res_nxt.bytes.final_byte = {2'b00, lvl_new, 3'b000};
					res_nxt.bytes.go         = GO_CMD;
				end
				res_nxt.power = fpow_new;
			end
		end else if (fit_any) begin
			res_nxt.kind       = KIND_PROG;
			res_nxt.bytes      = rq_bytes;
			res_nxt.current_ma = 14'({7'b0, prog_cur_q[fidx]} * 14'(CURRENT_STEP_MA));
		end
	end

	// state moves with the request into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PROG; i++) begin
				prog_cur_q[i] <= '0;
				prog_max_q[i] <= '0;
			end
			prog_min_q  <= '0;
			shadow_q    <= '0;
			fixed_lvl_q <= LVL_NONE;
			fixed_pow_q <= '0;
		end else if (advance) begin
			if (!cmd_s1) begin
				for (int i = 0; i < NUM_PROG; i++) begin
					prog_cur_q[i] <= pc_s1[i];
					prog_max_q[i] <= pmax_new[i];
				end
				prog_min_q  <= vcodes_s1[1:0];
				shadow_q    <= take_prog ? rq_bytes.final_byte : readback_s1;
				fixed_lvl_q <= lvl_new;
				fixed_pow_q <= fpow_new;
			end else if (fit_any) begin
				shadow_q <= rq_bytes.final_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign request_kind   = res_s2.kind;
	assign request_first  = res_s2.bytes.first;
	assign voltage_low    = res_s2.bytes.vlow;
	assign current_byte   = res_s2.bytes.cur;
	assign request_final  = res_s2.bytes.final_byte;
	assign go_byte        = res_s2.bytes.go;
	assign max_power      = res_s2.power;
	assign max_current_ma = res_s2.current_ma;

	// a full input register behind a stalled result must hold off new requests
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |-> in_stall)
		else $error("request accepted while both registers are held");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == KIND_NONE |->
		res_s2.bytes == '0 && res_s2.current_ma == '0)
		else $error("empty result carries request bytes");

	a_fixed_shape: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == KIND_FIXED |->
		res_s2.bytes.first == res_s2.bytes.final_byte && res_s2.bytes.vlow == '0
		&& res_s2.bytes.cur == '0 && res_s2.current_ma == '0)
		else $error("fixed request with programmable fields");

	a_user_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.current_ma != '0 |->
		res_s2.kind == KIND_PROG && res_s2.power == '0)
		else $error("user current without a programmable request");

	a_shadow_follow: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nxt.kind == KIND_PROG |=> shadow_q == res_s2.bytes.final_byte)
		else $error("request shadow not updated by programmable request");

endmodule

`default_nettype wire
